### src/eulbox_pkg.sv
package eulbox_pkg;

    localparam int QW      = 32;
    localparam int FRAC    = 16;
    localparam int PW      = 50;
    localparam int SW      = 34;
    localparam int CW      = 18;
    localparam int NAXES   = 3;
    localparam int CFG_IW  = 3;

    localparam logic [CFG_IW-1:0] CFG_TIME_STEP   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_RESTITUTION = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_FRICTION    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_BOUNDS_X    = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_BOUNDS_Y    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_BOUNDS_Z    = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [16:0] COEF_ONE      = 17'd65536;
    localparam logic [15:0] RST_TIME_STEP = 16'd546;
    localparam logic [16:0] RST_REST      = 17'd32768;
    localparam logic [16:0] RST_FRICTION  = 17'd0;
    localparam logic [63:0] RST_BOUNDS    = 64'h0001_0000_FFFF_0000;

    typedef logic signed [QW-1:0] t_q;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [SW-1:0] t_wide;
    typedef logic signed [CW-1:0] t_coef;

    typedef struct packed {
        t_q pos_x;
        t_q pos_y;
        t_q pos_z;
        t_q vel_x;
        t_q vel_y;
        t_q vel_z;
        t_q acc_x;
        t_q acc_y;
        t_q acc_z;
    } t_in_item;

    typedef struct packed {
        t_q         new_pos_x;
        t_q         new_pos_y;
        t_q         new_pos_z;
        t_q         new_vel_x;
        t_q         new_vel_y;
        t_q         new_vel_z;
        logic [2:0] hit_mask;
    } t_out_item;

    typedef struct packed {
        logic [15:0]                  dt;
        t_coef                        rest_neg;
        t_coef                        tscale;
        logic [NAXES-1:0][63:0]       bounds;
    } t_cfg;

    typedef struct packed {
        t_q [NAXES-1:0]   p;
        t_q [NAXES-1:0]   v;
        logic [NAXES-1:0] mask;
    } t_state;

    // product / 2^16, truncated toward zero
    function automatic t_wide q_shift(input t_prod x);
        t_prod adj;
        adj = x + (x[PW-1] ? t_prod'((1 << FRAC) - 1) : t_prod'(0));
        return t_wide'(adj[PW-1:FRAC]);
    endfunction

    function automatic t_q sat32(input t_wide x);
        t_q r;
        if ((x[SW-1:QW-1] == '0) || (x[SW-1:QW-1] == '1)) begin
            r = x[QW-1:0];
        end else if (x[SW-1]) begin
            r = {1'b1, {(QW-1){1'b0}}};
        end else begin
            r = {1'b0, {(QW-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [16:0] coef_clamp(input logic [16:0] c);
        return (c > COEF_ONE) ? COEF_ONE : c;
    endfunction

endpackage

### src/eulbox_cfg.sv
module eulbox_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [eulbox_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [63:0]                    i_cfg_data,
    output eulbox_pkg::t_cfg               o_cfg
);
    import eulbox_pkg::*;

    t_cfg r_cfg;

    // coefficients are stored already clamped: -restitution and 1 - friction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dt       <= RST_TIME_STEP;
            r_cfg.rest_neg <= -$signed({1'b0, RST_REST});
            r_cfg.tscale   <= $signed({1'b0, COEF_ONE - RST_FRICTION});
            r_cfg.bounds   <= {NAXES{RST_BOUNDS}};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TIME_STEP:   r_cfg.dt <= i_cfg_data[15:0];
                CFG_RESTITUTION: r_cfg.rest_neg <= -$signed({1'b0,
                                     coef_clamp(i_cfg_data[16:0])});
                CFG_FRICTION:    r_cfg.tscale <= $signed({1'b0,
                                     COEF_ONE - coef_clamp(i_cfg_data[16:0])});
                CFG_BOUNDS_X:    r_cfg.bounds[0] <= i_cfg_data;
                CFG_BOUNDS_Y:    r_cfg.bounds[1] <= i_cfg_data;
                CFG_BOUNDS_Z:    r_cfg.bounds[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/eulbox_integ.sv
module eulbox_integ (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  eulbox_pkg::t_in_item i_item,
    input  logic [15:0]          i_dt,
    output logic                 o_valid,
    output eulbox_pkg::t_state   o_state
);
    import eulbox_pkg::*;

    t_q [NAXES-1:0]    w_pos;
    t_q [NAXES-1:0]    w_vel;
    t_q [NAXES-1:0]    w_acc;
    logic signed [16:0] w_dt;

    logic [3:0]        r_valid;
    t_q [NAXES-1:0]    r_s1_pos;
    t_q [NAXES-1:0]    r_s1_vel;
    t_prod [NAXES-1:0] r_s1_prod;
    t_q [NAXES-1:0]    r_s2_pos;
    t_q [NAXES-1:0]    r_s2_vel;
    t_q [NAXES-1:0]    r_s3_pos;
    t_q [NAXES-1:0]    r_s3_vel;
    t_prod [NAXES-1:0] r_s3_prod;
    t_q [NAXES-1:0]    r_s4_pos;
    t_q [NAXES-1:0]    r_s4_vel;

    assign w_pos = {i_item.pos_z, i_item.pos_y, i_item.pos_x};
    assign w_vel = {i_item.vel_z, i_item.vel_y, i_item.vel_x};
    assign w_acc = {i_item.acc_z, i_item.acc_y, i_item.acc_x};
    assign w_dt  = $signed({1'b0, i_dt});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    // s1: a*dt, s2: v' = v + a*dt, s3: v'*dt, s4: p' = p + v'*dt
    always_ff @(posedge i_clk) begin
        for (int ax = 0; ax < NAXES; ax++) begin
            r_s1_pos[ax]  <= w_pos[ax];
            r_s1_vel[ax]  <= w_vel[ax];
            r_s1_prod[ax] <= t_prod'($signed(w_acc[ax])) * t_prod'(w_dt);

            r_s2_pos[ax]  <= r_s1_pos[ax];
            r_s2_vel[ax]  <= sat32(t_wide'($signed(r_s1_vel[ax]))
                                   + q_shift(r_s1_prod[ax]));

            r_s3_pos[ax]  <= r_s2_pos[ax];
            r_s3_vel[ax]  <= r_s2_vel[ax];
            r_s3_prod[ax] <= t_prod'($signed(r_s2_vel[ax])) * t_prod'(w_dt);

            r_s4_pos[ax]  <= sat32(t_wide'($signed(r_s3_pos[ax]))
                                   + q_shift(r_s3_prod[ax]));
            r_s4_vel[ax]  <= r_s3_vel[ax];
        end
    end

    assign o_valid      = r_valid[3];
    assign o_state.p    = r_s4_pos;
    assign o_state.v    = r_s4_vel;
    assign o_state.mask = '0;

endmodule

### src/eulbox_collide.sv
module eulbox_collide (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  eulbox_pkg::t_state i_state,
    input  logic [1:0]         i_axis,
    input  logic [63:0]        i_bounds,
    input  eulbox_pkg::t_coef  i_rest_neg,
    input  eulbox_pkg::t_coef  i_tscale,
    output logic               o_valid,
    output eulbox_pkg::t_state o_state
);
    import eulbox_pkg::*;

    t_q     w_p;
    t_q     w_vn;
    t_q     w_lo;
    t_q     w_hi;
    logic   w_below;
    logic   w_above;

    logic              r_a_valid;
    t_state            r_a_state;
    logic              r_a_hit;
    logic              r_a_flip;
    t_q                r_a_pclamp;
    t_prod             r_a_prod_n;
    t_prod [NAXES-1:0] r_a_prod_t;
    logic              r_b_valid;
    t_state            r_b_state;
    t_state            n_b_state;

    assign w_p     = i_state.p[i_axis];
    assign w_vn    = i_state.v[i_axis];
    assign w_lo    = i_bounds[31:0];
    assign w_hi    = i_bounds[63:32];
    assign w_below = $signed(w_p) < $signed(w_lo);
    assign w_above = !w_below && ($signed(w_p) > $signed(w_hi));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    // stage A: bound test and products, stage B: scale, saturate, select
    always_ff @(posedge i_clk) begin
        r_a_state  <= i_state;
        r_a_hit    <= w_below || w_above;
        r_a_flip   <= (w_below && $signed(w_vn) < 0) || (w_above && $signed(w_vn) > 0);
        r_a_pclamp <= w_below ? w_lo : w_hi;
        r_a_prod_n <= t_prod'($signed(w_vn)) * t_prod'(i_rest_neg);
        for (int t = 0; t < NAXES; t++) begin
            r_a_prod_t[t] <= t_prod'($signed(i_state.v[t])) * t_prod'(i_tscale);
        end
        r_b_state <= n_b_state;
    end

    always_comb begin
        n_b_state = r_a_state;
        for (int t = 0; t < NAXES; t++) begin
            if (2'(t) == i_axis) begin
                if (r_a_flip) begin
                    n_b_state.v[t] = sat32(q_shift(r_a_prod_n));
                end
                if (r_a_hit) begin
                    n_b_state.p[t] = r_a_pclamp;
                end
                n_b_state.mask[t] = r_a_state.mask[t] | r_a_hit;
            end else if (r_a_hit) begin
                n_b_state.v[t] = sat32(q_shift(r_a_prod_t[t]));
            end
        end
    end

    assign o_valid = r_b_valid;
    assign o_state = r_b_state;

endmodule

### src/particle_euler_box_collide_core.sv
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+--------------------------------------
// input     | start, busy (accept: !busy)   | i_item  (pos, vel, acc x/y/z)
// result    | o_valid, one cycle, no stall  | o_result (new pos, new vel, hit_mask)
// config    | i_cfg_valid, o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One item per cycle; busy stays low. The Euler update (two multiply/add
// pairs) comes first, then the wall tests for the x, y and z axes in turn.
// Synchronous active-low reset clears the valid chain and loads register defaults.
// The result is shown for one cycle only; the receiver cannot stall.
module particle_euler_box_collide_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  eulbox_pkg::t_in_item                i_item,
    output logic                                o_valid,
    output eulbox_pkg::t_out_item               o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [eulbox_pkg::CFG_IW-1:0]       i_cfg_index,
    input  logic [63:0]                         i_cfg_data
);
    import eulbox_pkg::*;

    t_cfg   w_cfg;
    logic   w_int_valid;
    t_state w_int_state;
    logic   w_x_valid;
    t_state w_x_state;
    logic   w_y_valid;
    t_state w_y_state;
    logic   w_z_valid;
    t_state w_z_state;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    eulbox_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    eulbox_integ u_integ (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .i_dt    (w_cfg.dt),
        .o_valid (w_int_valid),
        .o_state (w_int_state)
    );

    eulbox_collide u_col_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_int_valid),
        .i_state    (w_int_state),
        .i_axis     (AXIS_X),
        .i_bounds   (w_cfg.bounds[0]),
        .i_rest_neg (w_cfg.rest_neg),
        .i_tscale   (w_cfg.tscale),
        .o_valid    (w_x_valid),
        .o_state    (w_x_state)
    );

    eulbox_collide u_col_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_x_valid),
        .i_state    (w_x_state),
        .i_axis     (AXIS_Y),
        .i_bounds   (w_cfg.bounds[1]),
        .i_rest_neg (w_cfg.rest_neg),
        .i_tscale   (w_cfg.tscale),
        .o_valid    (w_y_valid),
        .o_state    (w_y_state)
    );

    eulbox_collide u_col_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_y_valid),
        .i_state    (w_y_state),
        .i_axis     (AXIS_Z),
        .i_bounds   (w_cfg.bounds[2]),
        .i_rest_neg (w_cfg.rest_neg),
        .i_tscale   (w_cfg.tscale),
        .o_valid    (w_z_valid),
        .o_state    (w_z_state)
    );

    assign o_valid            = w_z_valid;
    assign o_result.new_pos_x = w_z_state.p[0];
    assign o_result.new_pos_y = w_z_state.p[1];
    assign o_result.new_pos_z = w_z_state.p[2];
    assign o_result.new_vel_x = w_z_state.v[0];
    assign o_result.new_vel_y = w_z_state.v[1];
    assign o_result.new_vel_z = w_z_state.v[2];
    assign o_result.hit_mask  = w_z_state.mask;

endmodule

### src/eulbox_chk.sv
module eulbox_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_cfg_ready
);
    localparam int LAT = 10;

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted item gave no result");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result right after reset");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_rst_n, LAT) |-> $past(start && !busy, LAT))
        else $error("result without accepted item");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && o_cfg_ready)
        else $error("pipeline refused an item or a config write");

endmodule

bind particle_euler_box_collide_core eulbox_chk u_eulbox_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_cfg_ready (o_cfg_ready)
);
